@@ rtl/qrpt_pkg.sv @@
// ----------------------------------------------------------------------------
// qrpt_pkg: shared types and constants of the rigid point transform
// Fixed-point formats, payload beats, quaternion and register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package qrpt_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int QUAT_WIDTH  = 16;

    // quaternion products carry QFRAC2 fraction bits
    localparam int QFRAC2   = 2 * (QUAT_WIDTH - 1);
    localparam int MAT_FRAC = (QFRAC2 < (60 - COORD_WIDTH)) ? QFRAC2 : (60 - COORD_WIDTH);
    localparam int MAT_DROP = QFRAC2 - MAT_FRAC;

    localparam int QPROD_W = 2 * QUAT_WIDTH;
    localparam int MEX_W   = QFRAC2 + 4;
    localparam int MAT_W   = MAT_FRAC + 4;
    localparam int PROD_W  = MAT_W + COORD_WIDTH;
    localparam int ACC_W   = MAT_FRAC + COORD_WIDTH + 5;

    localparam int NUM_MAT   = 9;
    localparam int NUM_AXES  = 3;
    localparam int CFG_W     = (COORD_WIDTH > QUAT_WIDTH) ? COORD_WIDTH : QUAT_WIDTH;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [QUAT_WIDTH-1:0]  QUAT_ONE  = {1'b0, {(QUAT_WIDTH-1){1'b1}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_X  = 3'd0,
        REG_QUAT_Y  = 3'd1,
        REG_QUAT_Z  = 3'd2,
        REG_QUAT_W  = 3'd3,
        REG_SHIFT_X = 3'd4,
        REG_SHIFT_Y = 3'd5,
        REG_SHIFT_Z = 3'd6
    } cfg_reg_t;

    typedef logic signed [MAT_W-1:0]       mat_entry_t;
    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] x;
        logic signed [QUAT_WIDTH-1:0] y;
        logic signed [QUAT_WIDTH-1:0] z;
        logic signed [QUAT_WIDTH-1:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
        logic                          point_valid;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic                          clipped;
    } point_out_t;

endpackage

`default_nettype wire

@@ rtl/qrpt_matrix.sv @@
// ----------------------------------------------------------------------------
// qrpt_matrix: rotation matrix builder
// Three register stages: quaternion products, exact matrix entries, entries
// rounded to the matrix fraction width.
// ----------------------------------------------------------------------------
`default_nettype none

module qrpt_matrix
    import qrpt_pkg::*;
(
    input  logic       clk,
    input  quat_t      quat,
    output mat_entry_t mat [NUM_MAT]
);

    localparam logic signed [MEX_W-1:0] MAT_ONE = {4'b0001, {QFRAC2{1'b0}}};

    logic signed [QPROD_W-1:0] xx_reg, yy_reg, zz_reg;
    logic signed [QPROD_W-1:0] xy_reg, xz_reg, yz_reg;
    logic signed [QPROD_W-1:0] wx_reg, wy_reg, wz_reg;

    logic signed [MEX_W-1:0] mex_next [NUM_MAT];
    logic signed [MEX_W-1:0] mex_reg  [NUM_MAT];
    mat_entry_t              mat_next [NUM_MAT];
    mat_entry_t              mat_reg  [NUM_MAT];

    always_ff @(posedge clk)
    begin
        xx_reg <= QPROD_W'(quat.x) * QPROD_W'(quat.x);
        yy_reg <= QPROD_W'(quat.y) * QPROD_W'(quat.y);
        zz_reg <= QPROD_W'(quat.z) * QPROD_W'(quat.z);
        xy_reg <= QPROD_W'(quat.x) * QPROD_W'(quat.y);
        xz_reg <= QPROD_W'(quat.x) * QPROD_W'(quat.z);
        yz_reg <= QPROD_W'(quat.y) * QPROD_W'(quat.z);
        wx_reg <= QPROD_W'(quat.w) * QPROD_W'(quat.x);
        wy_reg <= QPROD_W'(quat.w) * QPROD_W'(quat.y);
        wz_reg <= QPROD_W'(quat.w) * QPROD_W'(quat.z);
    end

    always_comb
    begin
        mex_next[0] = MAT_ONE - ((MEX_W'(yy_reg) + MEX_W'(zz_reg)) <<< 1);
        mex_next[1] = (MEX_W'(xy_reg) - MEX_W'(wz_reg)) <<< 1;
        mex_next[2] = (MEX_W'(xz_reg) + MEX_W'(wy_reg)) <<< 1;
        mex_next[3] = (MEX_W'(xy_reg) + MEX_W'(wz_reg)) <<< 1;
        mex_next[4] = MAT_ONE - ((MEX_W'(xx_reg) + MEX_W'(zz_reg)) <<< 1);
        mex_next[5] = (MEX_W'(yz_reg) - MEX_W'(wx_reg)) <<< 1;
        mex_next[6] = (MEX_W'(xz_reg) - MEX_W'(wy_reg)) <<< 1;
        mex_next[7] = (MEX_W'(yz_reg) + MEX_W'(wx_reg)) <<< 1;
        mex_next[8] = MAT_ONE - ((MEX_W'(xx_reg) + MEX_W'(yy_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        mex_reg <= mex_next;
    end

    generate
        if (MAT_DROP == 0) begin : g_no_round
            always_comb
            begin
                for (int k = 0; k < NUM_MAT; k++)
                begin
                    mat_next[k] = MAT_W'(mex_reg[k]);
                end
            end
        end else begin : g_round
            localparam logic [MEX_W:0] MEX_HALF =
                {{(MEX_W + 1 - MAT_DROP){1'b0}}, 1'b1, {(MAT_DROP - 1){1'b0}}};
            logic [MEX_W:0] biased [NUM_MAT];

            // round to nearest, ties up
            always_comb
            begin
                for (int k = 0; k < NUM_MAT; k++)
                begin
                    biased[k]   = {mex_reg[k][MEX_W-1], mex_reg[k]} + MEX_HALF;
                    mat_next[k] = biased[k][MEX_W-1:MAT_DROP];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        mat_reg <= mat_next;
    end

    assign mat = mat_reg;

endmodule

`default_nettype wire

@@ rtl/quaternion_rigid_point_transform.sv @@
// ----------------------------------------------------------------------------
// quaternion_rigid_point_transform: rotate by a unit quaternion, then translate
// Throughput: one point per cycle unless res_stall holds the pipeline; six stages, each with a valid bit.
// A quaternion write reaches the datapath through a 3-stage matrix builder.
// Reset: pipeline empty, quaternion identity, translation zero.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_rigid_point_transform
    import qrpt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 pt_valid,
    output logic                 pt_stall,
    input  point_in_t            pt_data,

    output logic                 res_valid,
    input  logic                 res_stall,
    output point_out_t           res_data,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int NUM_STAGES = 6;

    quat_t      quat_reg;
    coord_t     shift_reg [NUM_AXES];
    mat_entry_t mat [NUM_MAT];

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    coord_t                   p0_reg [NUM_AXES];
    coord_t                   p1_reg [NUM_AXES];
    coord_t                   p2_reg [NUM_AXES];
    logic signed [PROD_W-1:0] prod_next [NUM_MAT];
    logic signed [PROD_W-1:0] prod_reg  [NUM_MAT];
    logic signed [ACC_W-1:0]  acc_next  [NUM_AXES];
    logic signed [ACC_W-1:0]  acc_reg   [NUM_AXES];
    logic [ACC_W:0]           biased    [NUM_AXES];
    logic [NUM_AXES-1:0]      ovf;
    coord_t                   sat       [NUM_AXES];
    point_out_t               res_next;
    point_out_t               res_reg;

    localparam logic [ACC_W:0] ACC_HALF =
        {{(ACC_W + 1 - MAT_FRAC){1'b0}}, 1'b1, {(MAT_FRAC - 1){1'b0}}};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.x <= '0;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
            quat_reg.w <= QUAT_ONE;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                shift_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_QUAT_X:  quat_reg.x   <= cfg_data[QUAT_WIDTH-1:0];
                REG_QUAT_Y:  quat_reg.y   <= cfg_data[QUAT_WIDTH-1:0];
                REG_QUAT_Z:  quat_reg.z   <= cfg_data[QUAT_WIDTH-1:0];
                REG_QUAT_W:  quat_reg.w   <= cfg_data[QUAT_WIDTH-1:0];
                REG_SHIFT_X: shift_reg[0] <= cfg_data[COORD_WIDTH-1:0];
                REG_SHIFT_Y: shift_reg[1] <= cfg_data[COORD_WIDTH-1:0];
                REG_SHIFT_Z: shift_reg[2] <= cfg_data[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    qrpt_matrix u_matrix (
        .clk  (clk),
        .quat (quat_reg),
        .mat  (mat)
    );

    // advance a stage when it is empty or the next one advances
    always_comb
    begin
        adv[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || !res_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign pt_stall = !adv[0];

    // drop invalid points at entry
    always_comb
    begin
        vld_next[0] = pt_valid && pt_data.point_valid;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // capture and align with the matrix builder
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            p0_reg[0] <= pt_data.in_x;
            p0_reg[1] <= pt_data.in_y;
            p0_reg[2] <= pt_data.in_z;
        end
        if (adv[1])
        begin
            p1_reg <= p0_reg;
        end
        if (adv[2])
        begin
            p2_reg <= p1_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                prod_next[3*i+j] = PROD_W'(mat[3*i+j]) * PROD_W'(p2_reg[j]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            acc_next[i] = ACC_W'(prod_reg[3*i]) + ACC_W'(prod_reg[3*i+1])
                        + ACC_W'(prod_reg[3*i+2]) + (ACC_W'(shift_reg[i]) <<< MAT_FRAC);
        end
    end

    // round to whole units, ties up, then saturate
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            biased[i] = {acc_reg[i][ACC_W-1], acc_reg[i]} + ACC_HALF;
            ovf[i]    = !((&biased[i][ACC_W:MAT_FRAC+COORD_WIDTH-1])
                       || !(|biased[i][ACC_W:MAT_FRAC+COORD_WIDTH-1]));
            if (ovf[i])
            begin
                sat[i] = biased[i][ACC_W] ? COORD_MIN : COORD_MAX;
            end
            else
            begin
                sat[i] = biased[i][MAT_FRAC+COORD_WIDTH-1:MAT_FRAC];
            end
        end
        res_next.out_x   = sat[0];
        res_next.out_y   = sat[1];
        res_next.out_z   = sat[2];
        res_next.clipped = |ovf;
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            prod_reg <= prod_next;
        end
        if (adv[4])
        begin
            acc_reg <= acc_next;
        end
        if (adv[5])
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = vld_reg[NUM_STAGES-1];
    assign res_data  = res_reg;

endmodule

`default_nettype wire
